// ----- sv/shp_pkg.sv -----
// Shared types, constants and configuration codes of the 3x3 sharpening filter.
package shp_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int CHANNELS    = 3;
  localparam int CHAN_W      = 8;
  localparam int CENTRE_GAIN = 5;
  localparam int MIN_DIM     = 3;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = COL_W + 1;
  localparam int HEIGHT_W = ROW_W + 1;
  localparam int SUM_W    = CHAN_W + 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HEIGHT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] pix_t;

  typedef struct packed {
    pix_t centre;
    pix_t north;
    pix_t south;
    pix_t west;
    pix_t east;
  } taps_t;

  typedef struct packed {
    logic             interior;
    logic             border;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

// ----- sv/shp_lane.sv -----
// One channel lane: 5*centre minus four neighbours, clamped to the sample range.
module shp_lane import shp_pkg::*; (
  input  chan_t centre_i,
  input  chan_t north_i,
  input  chan_t south_i,
  input  chan_t west_i,
  input  chan_t east_i,
  output chan_t sharp_o
);

  localparam logic [SUM_W-1:0] SAT_MAX = SUM_W'((1 << CHAN_W) - 1);

  logic [SUM_W-1:0] gain_sum;
  logic [SUM_W-1:0] neigh_sum;
  logic [SUM_W-1:0] diff;

  always_comb begin
    gain_sum  = SUM_W'(centre_i) * SUM_W'(CENTRE_GAIN);
    neigh_sum = SUM_W'(north_i) + SUM_W'(south_i) + SUM_W'(west_i) + SUM_W'(east_i);
    diff      = gain_sum - neigh_sum;
    if (gain_sum < neigh_sum) begin
      sharp_o = '0;
    end else if (diff > SAT_MAX) begin
      sharp_o = '1;
    end else begin
      sharp_o = diff[CHAN_W-1:0];
    end
  end

endmodule

// ----- sv/shp_window.sv -----
// Raster position, line stores and the 3x3 window feeding the lanes.
module shp_window import shp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  pix_t                pix_i,
  input  logic [WIDTH_W-1:0]  width_i,
  input  logic [HEIGHT_W-1:0] height_i,
  input  logic                adv_i,
  output logic                valid_o,
  output taps_t               taps_o,
  output pos_t                pos_o
);

  pix_t older_mem [MAX_WIDTH];
  pix_t prior_mem [MAX_WIDTH];

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             valid_q;
  pos_t             pos_q, pos_d;
  pix_t             pix_q;
  pix_t             above_q, above2_q;
  pix_t             top1_q, mid1_q, mid2_q, bot1_q;

  logic [HEIGHT_W-1:0] row_inc;
  logic [WIDTH_W-1:0]  col_inc;

  always_comb begin
    row_inc = HEIGHT_W'(row_q) + HEIGHT_W'(1);
    col_inc = WIDTH_W'(col_q) + WIDTH_W'(1);

    pos_d.row      = row_q;
    pos_d.col      = col_q;
    pos_d.interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2)) &&
                     (row_inc <= height_i) && (col_inc <= width_i);
    pos_d.border   = (row_q == '0) || (col_q == '0) ||
                     (row_inc >= height_i) || (col_inc >= width_i);

    if (col_inc >= width_i) begin
      col_d = '0;
      row_d = (row_inc >= height_i) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      valid_q <= 1'b0;
      top1_q  <= '0;
      mid1_q  <= '0;
      mid2_q  <= '0;
      bot1_q  <= '0;
    end else begin
      if (accept_i) begin
        row_q   <= row_d;
        col_q   <= col_d;
        valid_q <= 1'b1;
      end else if (adv_i) begin
        valid_q <= 1'b0;
      end
      if (adv_i) begin
        top1_q <= above2_q;
        mid1_q <= above_q;
        mid2_q <= mid1_q;
        bot1_q <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pos_q    <= pos_d;
      pix_q    <= pix_i;
      above_q  <= prior_mem[col_q];
      above2_q <= older_mem[col_q];
    end
    if (adv_i) begin
      older_mem[pos_q.col] <= above_q;
      prior_mem[pos_q.col] <= pix_q;
    end
  end

  assign valid_o       = valid_q;
  assign pos_o         = pos_q;
  assign taps_o.centre = mid1_q;
  assign taps_o.north  = top1_q;
  assign taps_o.south  = bot1_q;
  assign taps_o.west   = mid2_q;
  assign taps_o.east   = above_q;

endmodule

// ----- sv/shp_merge.sv -----
// Output stage: merges lane results and sends the interior and border results in order.
module shp_merge import shp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pos_t             pos_i,
  input  pix_t             sharp_i,
  input  logic             out_stall_i,
  output logic             ready_o,
  output logic             out_valid_o,
  output logic [ROW_W-1:0] out_row_o,
  output logic [COL_W-1:0] out_col_o,
  output pix_t             out_pix_o,
  output logic             last_o
);

  logic             int_q, bord_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  pix_t             val_q;
  logic             fire;

  assign out_valid_o = int_q || bord_q;
  assign fire        = out_valid_o && !out_stall_i;
  assign last_o      = !(int_q && bord_q);
  assign ready_o     = !out_valid_o || (fire && last_o);
  assign out_row_o   = int_q ? row_q - ROW_W'(1) : row_q;
  assign out_col_o   = int_q ? col_q - COL_W'(1) : col_q;
  assign out_pix_o   = int_q ? val_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q  <= 1'b0;
      bord_q <= 1'b0;
    end else if (load_i) begin
      int_q  <= pos_i.interior;
      bord_q <= pos_i.border;
    end else if (fire) begin
      if (int_q) begin
        int_q <= 1'b0;
      end else begin
        bord_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q <= pos_i.row;
      col_q <= pos_i.col;
      val_q <= sharp_i;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("request loaded while output stage busy");

  a_border_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> out_valid_o && last_o && !int_q)
    else $error("border result missing after interior result");

  a_interior_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int_q |-> (row_q != '0) && (col_q != '0))
    else $error("interior result at row or column zero");

endmodule

// ----- sv/sharpen_3x3_zero_border.sv -----
// Top level of the 3x3 sharpening filter with zero border over three-channel pixels.
// A request is registered in the window stage, then its results in the merge output register.
// Throughput: one request per cycle through the line stores and window while the output
// stage is ready; a request with two results holds the output register until the single result port has sent both.
// Reset: position counters, window and sizes (256 x 256) clear at once; the line stores
// are not cleared and need no clearing pass, so requests are taken right after reset.
module sharpen_3x3_zero_border import shp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CHAN_W-1:0]     chan_a_in_i,
  input  logic [CHAN_W-1:0]     chan_b_in_i,
  input  logic [CHAN_W-1:0]     chan_c_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic [CHAN_W-1:0]     chan_a_out_o,
  output logic [CHAN_W-1:0]     chan_b_out_o,
  output logic [CHAN_W-1:0]     chan_c_out_o,
  output logic                  last_of_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(256);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(256);

  logic [WIDTH_W-1:0]  width_q, width_eff;
  logic [HEIGHT_W-1:0] height_q, height_eff;
  logic                in_accept, s1_valid, s1_adv, merge_ready;
  pix_t                pix_in, sharp, out_pix;
  taps_t               taps;
  pos_t                pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WIDTH_W'(MIN_DIM)) begin
      width_eff = WIDTH_W'(MIN_DIM);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
    if (height_q < HEIGHT_W'(MIN_DIM)) begin
      height_eff = HEIGHT_W'(MIN_DIM);
    end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
      height_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
  end

  assign pix_in[0] = chan_a_in_i;
  assign pix_in[1] = chan_b_in_i;
  assign pix_in[2] = chan_c_in_i;

  assign s1_adv     = s1_valid && merge_ready;
  assign in_stall_o = s1_valid && !merge_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  shp_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .pix_i    (pix_in),
    .width_i  (width_eff),
    .height_i (height_eff),
    .adv_i    (s1_adv),
    .valid_o  (s1_valid),
    .taps_o   (taps),
    .pos_o    (pos)
  );

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    shp_lane u_lane (
      .centre_i (taps.centre[k]),
      .north_i  (taps.north[k]),
      .south_i  (taps.south[k]),
      .west_i   (taps.west[k]),
      .east_i   (taps.east[k]),
      .sharp_o  (sharp[k])
    );
  end

  shp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv),
    .pos_i       (pos),
    .sharp_i     (sharp),
    .out_stall_i (out_stall_i),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_pix_o   (out_pix),
    .last_o      (last_of_item_o)
  );

  assign chan_a_out_o = out_pix[0];
  assign chan_b_out_o = out_pix[1];
  assign chan_c_out_o = out_pix[2];

endmodule

// ----- tb/sv/tb_sharpen_3x3_zero_border.sv -----
// Self-checking testbench for the 3x3 zero-border sharpening filter: directed and random frames.
`timescale 1ns / 100ps

module tb_sharpen_3x3_zero_border;
  import shp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_REPORTS   = 30;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             chans;
    logic             last;
  } sharpened_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CHAN_W-1:0]     chan_a_in_i = '0;
  logic [CHAN_W-1:0]     chan_b_in_i = '0;
  logic [CHAN_W-1:0]     chan_c_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ROW_W-1:0]      out_row_o;
  logic [COL_W-1:0]      out_col_o;
  logic [CHAN_W-1:0]     chan_a_out_o;
  logic [CHAN_W-1:0]     chan_b_out_o;
  logic [CHAN_W-1:0]     chan_c_out_o;
  logic                  last_of_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // frame model
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  pix_t                older_line [MAX_WIDTH];
  pix_t                prior_line [MAX_WIDTH];
  pix_t                top_near, mid_near, mid_far, bot_near;
  int unsigned         row_pos, col_pos;
  sharpened_t          sharpened_q [$];

  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned interior_count = 0;
  int unsigned size_writes = 0;
  int unsigned mismatches = 0;

  sharpen_3x3_zero_border dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .chan_a_in_i    (chan_a_in_i),
    .chan_b_in_i    (chan_b_in_i),
    .chan_c_in_i    (chan_c_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .chan_a_out_o   (chan_a_out_o),
    .chan_b_out_o   (chan_b_out_o),
    .chan_c_out_o   (chan_c_out_o),
    .last_of_item_o (last_of_item_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sharpened_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic chan_t sharpen_chan(chan_t centre, chan_t n, chan_t s, chan_t w, chan_t e);
    int acc;
    acc = CENTRE_GAIN * int'(centre) - int'(n) - int'(s) - int'(w) - int'(e);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return chan_t'(acc);
  endfunction

  function automatic pix_t pick_pixel();
    pix_t px;
    for (int k = 0; k < CHANNELS; k++) begin
      case ($urandom_range(0, 9))
        0: px[k] = '0;
        1: px[k] = '1;
        default: px[k] = chan_t'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  task automatic reset_model();
    width_reg  = WIDTH_W'(256);
    height_reg = HEIGHT_W'(256);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_line[i] = '0;
      prior_line[i] = '0;
    end
    top_near = '0;
    mid_near = '0;
    mid_far  = '0;
    bot_near = '0;
    row_pos  = 0;
    col_pos  = 0;
  endtask

  task automatic predict_sharpen(input pix_t px);
    int unsigned w_eff, h_eff, r, c;
    pix_t        above, above2;
    sharpened_t  res;
    logic        at_border;
    w_eff = eff_size(width_reg, MAX_WIDTH);
    h_eff = eff_size(height_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    above  = prior_line[c];
    above2 = older_line[c];
    at_border = (r == 0) || (c == 0) || (r >= h_eff - 1) || (c >= w_eff - 1);
    if (r >= 2 && c >= 2 && r - 1 <= h_eff - 2 && c - 1 <= w_eff - 2) begin
      res.row = ROW_W'(r - 1);
      res.col = COL_W'(c - 1);
      for (int k = 0; k < CHANNELS; k++)
        res.chans[k] = sharpen_chan(mid_near[k], top_near[k], bot_near[k], mid_far[k], above[k]);
      res.last = !at_border;
      sharpened_q.push_back(res);
      interior_count++;
    end
    if (at_border) begin
      res.row   = ROW_W'(r);
      res.col   = COL_W'(c);
      res.chans = '0;
      res.last  = 1'b1;
      sharpened_q.push_back(res);
    end
    top_near = above2;
    mid_far  = mid_near;
    mid_near = above;
    bot_near = px;
    older_line[c] = above;
    prior_line[c] = px;
    if (c + 1 >= w_eff) begin
      col_pos = 0;
      row_pos = (r + 1 >= h_eff) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic compare_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    sharpened_t want;
    pix_t       got_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (sharpened_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none actual row %0d col %0d",
                   $time, out_row_o, out_col_o);
      end else begin
        want   = sharpened_q.pop_front();
        got_px = {chan_c_out_o, chan_b_out_o, chan_a_out_o};
        compare_field("row", want.row, out_row_o);
        compare_field("col", want.col, out_col_o);
        for (int k = 0; k < CHANNELS; k++)
          compare_field($sformatf("chan %0d at %0d,%0d", k, want.row, want.col),
                        want.chans[k], got_px[k]);
        compare_field("last_of_item", want.last, last_of_item_o);
      end
    end
  end

  always @(posedge clk_i) begin : output_throttle
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_pixel(input pix_t px);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    chan_a_in_i <= px[0];
    chan_b_in_i <= px[1];
    chan_c_in_i <= px[2];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_sharpen(px);
    pixels_sent++;
  endtask

  task automatic finish_frame();
    while (row_pos != 0 || col_pos != 0)
      send_pixel(pick_pixel());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_size(input bit set_w, input logic [CFG_DATA_W-1:0] w_val,
                              input bit set_h, input logic [CFG_DATA_W-1:0] h_val);
    cfg_idx_e              idx [2];
    logic [CFG_DATA_W-1:0] val [2];
    int                    cnt;
    cnt = 0;
    if (set_w) begin
      idx[cnt] = CFG_WIDTH;
      val[cnt] = w_val;
      cnt++;
    end
    if (set_h) begin
      idx[cnt] = CFG_HEIGHT;
      val[cnt] = h_val;
      cnt++;
    end
    for (int i = 0; i < cnt; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      if (idx[i] == CFG_WIDTH) width_reg = val[i][WIDTH_W-1:0];
      else height_reg = val[i];
      size_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_sizes();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (10) send_pixel(pick_pixel());
    wait_idle();
    // shrink mid-row: the current column lies past the new right edge
    program_size(1'b1, CFG_DATA_W'(3), 1'b1, CFG_DATA_W'(3));
    finish_frame();
  endtask

  task automatic test_clamp_limits();
    logic [11:0] bright;
    pix_t        px;
    bright = 12'b0100_1010_0100;
    wait_idle();
    // width carries junk above its 11 bits; height below the minimum
    program_size(1'b1, CFG_DATA_W'('h1804), 1'b1, CFG_DATA_W'(0));
    for (int i = 0; i < 12; i++) begin
      px[0] = bright[i] ? 8'd255 : 8'd0;
      px[1] = ~px[0];
      px[2] = 8'd128;
      send_pixel(px);
    end
  endtask

  task automatic test_tall_frame();
    wait_idle();
    program_size(1'b1, CFG_DATA_W'(2), 1'b1, CFG_DATA_W'(8191));
    repeat (15) send_pixel(pick_pixel());
    wait_idle();
    program_size(1'b0, '0, 1'b1, CFG_DATA_W'(3));
    finish_frame();
  endtask

  task automatic test_max_width();
    wait_idle();
    program_size(1'b1, CFG_DATA_W'(2047), 1'b1, CFG_DATA_W'(3));
    repeat (40) send_pixel(pick_pixel());
    wait_idle();
    // shrink mid-row, then close the frame at the minimum width
    program_size(1'b1, CFG_DATA_W'(3), 1'b0, '0);
    finish_frame();
  endtask

  task automatic test_output_holdoff();
    wait_idle();
    program_size(1'b1, CFG_DATA_W'(8), 1'b1, CFG_DATA_W'(6));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_toggle <= ~hold_toggle;
    repeat (96) send_pixel(pick_pixel());
  endtask

  task automatic test_random_frames(input int unsigned budget);
    int unsigned           start_cnt, w_eff, h_eff, part;
    logic [CFG_DATA_W-1:0] w_pick, h_pick;
    start_cnt = pixels_sent;
    while (pixels_sent - start_cnt < budget) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: w_pick = CFG_DATA_W'($urandom_range(0, 2));
        1: w_pick = CFG_DATA_W'(MIN_DIM);
        2: w_pick = CFG_DATA_W'($urandom_range(30, 64));
        default: w_pick = CFG_DATA_W'($urandom_range(3, 16));
      endcase
      case ($urandom_range(0, 5))
        0: h_pick = CFG_DATA_W'($urandom_range(0, 2));
        1: h_pick = CFG_DATA_W'(MIN_DIM);
        default: h_pick = CFG_DATA_W'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 5))
        0: program_size(1'b1, w_pick, 1'b0, '0);
        1: program_size(1'b0, '0, 1'b1, h_pick);
        default: program_size(1'b1, w_pick, 1'b1, h_pick);
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      w_eff = eff_size(width_reg, MAX_WIDTH);
      h_eff = eff_size(height_reg, MAX_HEIGHT);
      if ($urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, w_eff * h_eff - 1);
        repeat (part) send_pixel(pick_pixel());
        wait_idle();
        // shrink only, so every line store entry read below was written this frame
        if ($urandom_range(0, 1) == 1)
          program_size(1'b1, CFG_DATA_W'($urandom_range(MIN_DIM, w_eff)), 1'b0, '0);
        else
          program_size(1'b0, '0, 1'b1, CFG_DATA_W'($urandom_range(MIN_DIM, h_eff)));
        finish_frame();
      end else begin
        repeat ($urandom_range(1, 2)) begin
          send_pixel(pick_pixel());
          finish_frame();
        end
      end
    end
  endtask

  task automatic test_steady_tail();
    wait_idle();
    program_size(1'b1, CFG_DATA_W'(6), 1'b1, CFG_DATA_W'(5));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (60) send_pixel(pick_pixel());
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_sizes();
    test_clamp_limits();
    test_tall_frame();
    test_max_width();
    test_output_holdoff();
    test_random_frames(350);
    test_steady_tail();
    wait_idle();
    $display("%0d pixels in, %0d results checked, %0d of them sharpened, %0d size writes",
             pixels_sent, results_checked, interior_count, size_writes);
    $display("frames from 3x3 to 64 wide, sizes clamped to 1024 wide and 4096 tall,");
    $display("mid-frame shrink, long output hold-off");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
